FILE: rtl/bir_pkg.sv
`timescale 1ns / 1ps

package bir_pkg;

	localparam int MAX_SRC_DIM_DEF = 64;
	localparam int SAMPLE_BITS = 24;
	localparam int WGT_W = 17;
	localparam int BASE_W = 21;
	localparam int SIZE_W = 7;
	localparam int DST_W = 13;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 13;
	localparam int ACC_W = 2 * WGT_W + SAMPLE_BITS + 4;

	typedef enum logic {
		OP_LOAD    = 1'b0,
		OP_COMPUTE = 1'b1
	} op_t;

	localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DST_HEIGHT = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DST_WIDTH  = 2'd3;

	typedef logic signed [WGT_W-1:0] wgt_t;
	typedef wgt_t [3:0] wvec_t;

	typedef struct packed {
		logic signed [BASE_W-1:0] base;
		wvec_t                    w;
	} axis_res_t;

	typedef struct packed {
		op_t                           op;
		logic [5:0]                    load_row;
		logic [5:0]                    load_col;
		logic signed [SAMPLE_BITS-1:0] load_value;
		logic [11:0]                   out_row;
		logic [11:0]                   out_col;
	} in_item_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] pixel;
		logic                          saturated;
	} out_item_t;

endpackage

FILE: rtl/bir_axis.sv
`timescale 1ns / 1ps

module bir_axis (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [11:0]         o,
	input  logic [6:0]          s,
	input  logic [12:0]         d,
	output logic                done,
	output bir_pkg::axis_res_t  res
);
	import bir_pkg::*;

	localparam int DIV_STEPS = 36;
	localparam logic signed [53:0] K50 = 54'sd1 <<< 50;
	localparam logic signed [53:0] KH = 54'sd1 <<< 35;

	typedef enum logic [2:0] {
		A_IDLE, A_MAP, A_DIV, A_W1, A_W2, A_W3, A_W4
	} state_t;

	state_t state_q;
	logic signed [20:0] n_q;
	logic [13:0] den_q;
	logic [35:0] num_q;
	logic [13:0] rem_q;
	logic [5:0]  cnt_q;
	logic        neg_q;
	logic [15:0] t_q;
	logic [16:0] u_q;
	logic [31:0] tt_q, tu_q;
	logic [32:0] uu_q;
	logic [47:0] ttt_q;
	logic [48:0] ttu_q, tuu_q, uuu_q;

	logic [19:0] m_c;
	logic signed [20:0] n_c, nd_c;
	logic [14:0] trial_c, diff_c;
	logic        ge_c;
	logic [51:0] e0_c, e3_c;
	logic signed [53:0] e1_c, e2_c, s1_c, s2_c;

	always_comb begin
		m_c = 20'({o, 1'b1}) * 20'(s);
		n_c = $signed({1'b0, m_c}) - $signed({8'd0, d});
		nd_c = n_q + $signed({7'd0, den_q});
		trial_c = {rem_q, num_q[35]};
		ge_c = trial_c >= {1'b0, den_q};
		diff_c = trial_c - {1'b0, den_q};
		e0_c = 52'(tuu_q) * 52'd3 + (52'd1 << 35);
		e3_c = 52'(ttu_q) * 52'd3 + (52'd1 << 35);
		e1_c = 54'sd5 * $signed({6'd0, ttt_q}) - 54'sd9 * $signed({6'd0, tt_q, 16'd0})
			+ K50 + KH;
		e2_c = 54'sd5 * $signed({5'd0, uuu_q}) - 54'sd9 * $signed({5'd0, uu_q, 16'd0})
			+ K50 + KH;
		s1_c = e1_c >>> 36;
		s2_c = e2_c >>> 36;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= A_IDLE;
			done <= 1'b0;
			n_q <= '0;
			den_q <= '0;
			num_q <= '0;
			rem_q <= '0;
			cnt_q <= '0;
			neg_q <= 1'b0;
			t_q <= '0;
			u_q <= '0;
			tt_q <= '0;
			tu_q <= '0;
			uu_q <= '0;
			ttt_q <= '0;
			ttu_q <= '0;
			tuu_q <= '0;
			uuu_q <= '0;
			res <= '0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				A_IDLE: begin
					if (start) begin
						n_q <= n_c;
						den_q <= {d, 1'b0};
						state_q <= A_MAP;
					end
				end
				A_MAP: begin
					neg_q <= n_q[20];
					if (n_q[20]) begin
						num_q <= 36'({nd_c[13:0], 16'd0});
					end else begin
						num_q <= {n_q[19:0], 16'd0};
					end
					rem_q <= '0;
					cnt_q <= '0;
					state_q <= A_DIV;
				end
				A_DIV: begin
					rem_q <= ge_c ? diff_c[13:0] : trial_c[13:0];
					num_q <= {num_q[34:0], ge_c};
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'(DIV_STEPS - 1)) begin
						state_q <= A_W1;
					end
				end
				A_W1: begin
					t_q <= num_q[15:0];
					u_q <= 17'h10000 - {1'b0, num_q[15:0]};
					res.base <= neg_q ? -21'sd1 : $signed({1'b0, num_q[35:16]});
					state_q <= A_W2;
				end
				A_W2: begin
					tt_q <= 32'(t_q) * 32'(t_q);
					tu_q <= 32'(t_q) * 32'(u_q);
					uu_q <= 33'(u_q) * 33'(u_q);
					state_q <= A_W3;
				end
				A_W3: begin
					ttt_q <= 48'(tt_q) * 48'(t_q);
					ttu_q <= 49'(tt_q) * 49'(u_q);
					tuu_q <= 49'(tu_q) * 49'(u_q);
					uuu_q <= 49'(uu_q) * 49'(u_q);
					state_q <= A_W4;
				end
				A_W4: begin
					res.w[0] <= -$signed(17'(e0_c >> 36));
					res.w[1] <= s1_c[16:0];
					res.w[2] <= s2_c[16:0];
					res.w[3] <= -$signed(17'(e3_c >> 36));
					done <= 1'b1;
					state_q <= A_IDLE;
				end
				default: state_q <= A_IDLE;
			endcase
		end
	end

endmodule

FILE: rtl/bir_core.sv
`timescale 1ns / 1ps

module bir_core #(
	parameter int MAX_SRC_DIM = bir_pkg::MAX_SRC_DIM_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  bir_pkg::in_item_t   item,
	input  logic                start,
	input  bir_pkg::axis_res_t  ay,
	input  bir_pkg::axis_res_t  ax,
	input  logic [6:0]          sh,
	input  logic [6:0]          sw,
	output logic                out_valid,
	input  logic                out_stall,
	output bir_pkg::out_item_t  out_item,
	output logic                done
);
	import bir_pkg::*;

	localparam int DEPTH = MAX_SRC_DIM * MAX_SRC_DIM;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam logic signed [ACC_W-1:0] RND_K = ACC_W'(2 ** 27);
	localparam logic signed [ACC_W-1:0] HI_K = ACC_W'(2 ** (SAMPLE_BITS - 1) - 1);
	localparam logic signed [ACC_W-1:0] LO_K = -HI_K - ACC_W'(1);

	typedef enum logic [1:0] {
		C_IDLE, C_TAPS, C_DRAIN, C_RESULT
	} state_t;

	logic signed [SAMPLE_BITS-1:0] mem [DEPTH];
	logic signed [SAMPLE_BITS-1:0] rdata_s1;

	state_t state_q;
	logic [3:0] cnt_q;
	logic v_s1, last_s1, v_s2, last_s2;
	logic signed [2*WGT_W-1:0] wp_s1;
	logic signed [2*WGT_W+SAMPLE_BITS-1:0] prod_s2;
	logic signed [ACC_W-1:0] acc_q;

	logic we_c;
	logic [ADDR_W-1:0] waddr_c, raddr_c;
	logic [1:0] j_c, i_c;
	logic signed [21:0] ry_w, cx_w;
	logic [6:0] ry_c, cx_c;
	logic signed [ACC_W-1:0] rnd_c, shr_c;
	out_item_t res_c;

	always_comb begin
		we_c = load && (32'(item.load_row) < MAX_SRC_DIM) && (32'(item.load_col) < MAX_SRC_DIM);
		waddr_c = ADDR_W'(item.load_row) * ADDR_W'(MAX_SRC_DIM) + ADDR_W'(item.load_col);
		j_c = cnt_q[3:2];
		i_c = cnt_q[1:0];
		ry_w = 22'(ay.base) + $signed({20'd0, j_c}) - 22'sd1;
		cx_w = 22'(ax.base) + $signed({20'd0, i_c}) - 22'sd1;
		if (ry_w < 0) begin
			ry_c = '0;
		end else if (ry_w > $signed({15'd0, sh}) - 22'sd1) begin
			ry_c = sh - 7'd1;
		end else begin
			ry_c = ry_w[6:0];
		end
		if (cx_w < 0) begin
			cx_c = '0;
		end else if (cx_w > $signed({15'd0, sw}) - 22'sd1) begin
			cx_c = sw - 7'd1;
		end else begin
			cx_c = cx_w[6:0];
		end
		raddr_c = ADDR_W'(ry_c) * ADDR_W'(MAX_SRC_DIM) + ADDR_W'(cx_c);
		rnd_c = acc_q + RND_K;
		shr_c = rnd_c >>> 28;
		if (shr_c > HI_K) begin
			res_c.pixel = HI_K[SAMPLE_BITS-1:0];
			res_c.saturated = 1'b1;
		end else if (shr_c < LO_K) begin
			res_c.pixel = LO_K[SAMPLE_BITS-1:0];
			res_c.saturated = 1'b1;
		end else begin
			res_c.pixel = shr_c[SAMPLE_BITS-1:0];
			res_c.saturated = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (we_c) begin
			mem[waddr_c] <= item.load_value;
		end
		rdata_s1 <= mem[raddr_c];
	end

	always_ff @(posedge clk) begin
		wp_s1 <= $signed(ay.w[j_c]) * $signed(ax.w[i_c]);
		prod_s2 <= wp_s1 * rdata_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			cnt_q <= '0;
			v_s1 <= 1'b0;
			last_s1 <= 1'b0;
			v_s2 <= 1'b0;
			last_s2 <= 1'b0;
			acc_q <= '0;
			out_valid <= 1'b0;
			out_item <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			v_s1 <= (state_q == C_TAPS);
			last_s1 <= (cnt_q == 4'd15);
			v_s2 <= v_s1;
			last_s2 <= last_s1;
			if (v_s2) begin
				acc_q <= acc_q + prod_s2;
			end
			if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				C_IDLE: begin
					if (start) begin
						acc_q <= '0;
						cnt_q <= '0;
						state_q <= C_TAPS;
					end
				end
				C_TAPS: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'd15) begin
						state_q <= C_DRAIN;
					end
				end
				C_DRAIN: begin
					if (v_s2 && last_s2) begin
						state_q <= C_RESULT;
					end
				end
				C_RESULT: begin
					if (!out_valid || !out_stall) begin
						out_valid <= 1'b1;
						out_item <= res_c;
						done <= 1'b1;
						state_q <= C_IDLE;
					end
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

endmodule

FILE: rtl/bicubic_image_resize.sv
`timescale 1ns / 1ps

// Bicubic image resizer, Keys kernel (A = -0.75), one signed Q8.16 plane.
// Input channel (in_valid / in_stall / in_item): op OP_LOAD writes one source
// sample into the on-chip sample memory; no result follows.
// op OP_COMPUTE names an output pixel and yields exactly one result item.
// Output channel (out_valid / out_stall / out_item): pixel and saturated flag,
// held in an output register until taken.
// Config port: cfg_we, cfg_index, cfg_data; write only while the block is idle.
// A compute item passes from acceptance to out_valid through a map step,
// a 36-step radix-2 divider per axis (both axes in parallel) for position and
// fraction, the weight multiplies, a handoff to the core, 16 taps read one per
// cycle from the sample memory (one read and one write port), the drain of
// the multiply-accumulate pipeline and a result step. in_stall falls in the
// cycle after the result is registered, so compute items never overlap;
// loads are taken every cycle while no compute item is in flight.
// If the receiver stalls, the finished result waits in the core and the block
// takes no new item until the output register frees up.
// Reset clears control state and restores the size registers (64x64 source,
// 256x256 output). Sample memory is not cleared: load before use.

module bicubic_image_resize #(
	parameter int MAX_SRC_DIM = bir_pkg::MAX_SRC_DIM_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [bir_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [bir_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  bir_pkg::in_item_t                   in_item,
	output logic                                out_valid,
	input  logic                                out_stall,
	output bir_pkg::out_item_t                  out_item
);
	import bir_pkg::*;

	logic [SIZE_W-1:0] src_h_q, src_w_q;
	logic [DST_W-1:0] dst_h_q, dst_w_q;
	logic busy_q;

	logic accept_c, start_c, load_c;
	logic [SIZE_W-1:0] sh_c, sw_c;
	logic [DST_W-1:0] dh_c, dw_c;
	logic done_y, done_x, core_done;
	axis_res_t res_y, res_x;

	assign in_stall = busy_q;
	assign accept_c = in_valid && !busy_q;
	assign start_c = accept_c && (in_item.op == OP_COMPUTE);
	assign load_c = accept_c && (in_item.op == OP_LOAD);

	always_comb begin
		if (src_h_q == '0) begin
			sh_c = SIZE_W'(1);
		end else if (32'(src_h_q) > MAX_SRC_DIM) begin
			sh_c = SIZE_W'(MAX_SRC_DIM);
		end else begin
			sh_c = src_h_q;
		end
		if (src_w_q == '0) begin
			sw_c = SIZE_W'(1);
		end else if (32'(src_w_q) > MAX_SRC_DIM) begin
			sw_c = SIZE_W'(MAX_SRC_DIM);
		end else begin
			sw_c = src_w_q;
		end
		dh_c = (dst_h_q == '0) ? DST_W'(1) : dst_h_q;
		dw_c = (dst_w_q == '0) ? DST_W'(1) : dst_w_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_h_q <= SIZE_W'(64);
			src_w_q <= SIZE_W'(64);
			dst_h_q <= DST_W'(256);
			dst_w_q <= DST_W'(256);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SRC_HEIGHT: src_h_q <= cfg_data[SIZE_W-1:0];
				CFG_SRC_WIDTH:  src_w_q <= cfg_data[SIZE_W-1:0];
				CFG_DST_HEIGHT: dst_h_q <= cfg_data;
				CFG_DST_WIDTH:  dst_w_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start_c) begin
			busy_q <= 1'b1;
		end else if (core_done) begin
			busy_q <= 1'b0;
		end
	end

	bir_axis u_axis_y (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_c),
		.o      (in_item.out_row),
		.s      (sh_c),
		.d      (dh_c),
		.done   (done_y),
		.res    (res_y)
	);

	bir_axis u_axis_x (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_c),
		.o      (in_item.out_col),
		.s      (sw_c),
		.d      (dw_c),
		.done   (done_x),
		.res    (res_x)
	);

	bir_core #(
		.MAX_SRC_DIM (MAX_SRC_DIM)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load_c),
		.item      (in_item),
		.start     (done_y && done_x),
		.ay        (res_y),
		.ax        (res_x),
		.sh        (sh_c),
		.sw        (sw_c),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.done      (core_done)
	);

endmodule

FILE: rtl/bir_checker.sv
`timescale 1ns / 1ps

module bir_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_stall,
	input bir_pkg::in_item_t   in_item,
	input logic                out_valid,
	input logic                out_stall,
	input bir_pkg::out_item_t  out_item
);
	import bir_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item))
		else $error("stalled result item changed or dropped");

	a_compute_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && in_item.op == OP_COMPUTE |=> in_stall)
		else $error("compute item did not make the block busy");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && in_item.op == OP_LOAD |=> !in_stall)
		else $error("load item stalled the input");

	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result item without a compute item in flight");

endmodule

bind bicubic_image_resize bir_checker u_bir_checker (.*);
